// ===== hdl/dndc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dndc_pkg: shared types and constants of the day number / date converter
// Field widths, calendar block lengths and small calendar tables.
// ----------------------------------------------------------------------------
package dndc_pkg;

	localparam int COUNT_W = 22;   // day count field
	localparam int DAYS_W  = 23;   // absolute day numbers and intermediate sums
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int Q100_W  = 7;    // year / 100 for years up to 12000
	localparam int OFS_W   = 9;    // day-of-year offset of a month start

	// block lengths in days
	localparam logic [DAYS_W-1:0] DAYS_400Y = 23'd146097;
	localparam logic [DAYS_W-1:0] DAYS_100Y = 23'd36524;
	localparam logic [DAYS_W-1:0] DAYS_4Y   = 23'd1461;
	localparam logic [DAYS_W-1:0] DAYS_1Y   = 23'd365;

	// x / 100 == (x * 5243) >> 19 for x below 43699
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          RECIP_SHR  = 19;
	localparam logic [8:0]  DAYS_YEAR  = 9'd365;
	localparam logic [6:0]  HUNDRED    = 7'd100;

	localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;  // December, zero based

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;   // 1..12
		logic [DAY_W-1:0]   day;     // 1..31
	} date_t;

	// days from 1 Jan of year 1 to 1 Jan of year y, elaboration only
	function automatic int days_before_year(int y);
		int p;
		p = y - 1;
		return 365 * p + p / 4 - p / 100 + p / 400;
	endfunction

	// length of zero-based month m
	function automatic logic [DAY_W-1:0] month_len(logic leap, logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// days in the year before the start of zero-based month m
	function automatic logic [OFS_W-1:0] month_offset(logic leap, logic [MONTH_W-1:0] m);
		logic [OFS_W-1:0] ofs;
		unique case (m)
			4'd0:    ofs = 9'd0;
			4'd1:    ofs = 9'd31;
			4'd2:    ofs = 9'd59;
			4'd3:    ofs = 9'd90;
			4'd4:    ofs = 9'd120;
			4'd5:    ofs = 9'd151;
			4'd6:    ofs = 9'd181;
			4'd7:    ofs = 9'd212;
			4'd8:    ofs = 9'd243;
			4'd9:    ofs = 9'd273;
			4'd10:   ofs = 9'd304;
			default: ofs = 9'd334;
		endcase
		if (leap && m >= 4'd2) begin
			ofs = ofs + 9'd1;
		end
		return ofs;
	endfunction

	// (sw + c) mod 7, folding octal digits since 8 == 1 mod 7
	function automatic logic [WDAY_W-1:0] mod7(logic [COUNT_W-1:0] c, logic [WDAY_W-1:0] sw);
		logic [5:0] s;
		logic [3:0] t;
		logic [3:0] u;
		s = 6'(c[2:0]) + 6'(c[5:3]) + 6'(c[8:6]) + 6'(c[11:9]) + 6'(c[14:12])
		  + 6'(c[17:15]) + 6'(c[20:18]) + 6'(c[21]) + 6'(sw);
		t = 4'(s[5:3]) + 4'(s[2:0]);
		u = 4'(t[3]) + 4'(t[2:0]);
		if (u >= 4'd7) begin
			u = u - 4'd7;
		end
		return u[2:0];
	endfunction

endpackage

// ===== hdl/dndc_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dndc_split: iterative day number to date splitter
// One subtract/compare unit peels 400, 100, 4 and 1 year blocks, then months.
// ----------------------------------------------------------------------------
module dndc_split (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dndc_pkg::DAYS_W-1:0]   n_days,   // days since 1 Jan of year 1
	output logic                          done,
	output dndc_pkg::date_t               res
);

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_400  = 6'b000010,
		PH_100  = 6'b000100,
		PH_4    = 6'b001000,
		PH_1    = 6'b010000,
		PH_MON  = 6'b100000
	} phase_t;

	phase_t                             phase_q;
	logic                               done_q;
	logic [dndc_pkg::DAYS_W-1:0]        rem_q;
	logic [dndc_pkg::YEAR_W-1:0]        year_q;
	logic [dndc_pkg::MONTH_W-1:0]       mon_q;
	logic [1:0]                         c100_q;
	logic [4:0]                         c4_q;
	logic [1:0]                         c1_q;

	logic [dndc_pkg::DAYS_W-1:0]        k;
	logic [dndc_pkg::YEAR_W-1:0]        inc;
	logic [dndc_pkg::DAYS_W:0]          diff;
	logic                               ge;
	logic                               take;
	logic                               leap;

	// last year of a 4 year block is leap, except at a century not divisible by 400
	assign leap = (c1_q == 2'd3) && ((c4_q != 5'd24) || (c100_q == 2'd3));

	always_comb begin
		k   = dndc_pkg::DAYS_1Y;
		inc = '0;
		unique case (phase_q)
			PH_400:  begin k = dndc_pkg::DAYS_400Y; inc = 14'd400; end
			PH_100:  begin k = dndc_pkg::DAYS_100Y; inc = 14'd100; end
			PH_4:    begin k = dndc_pkg::DAYS_4Y;   inc = 14'd4;   end
			PH_1:    begin k = dndc_pkg::DAYS_1Y;   inc = 14'd1;   end
			PH_MON:  begin
				k   = dndc_pkg::DAYS_W'(dndc_pkg::month_len(leap, mon_q));
				inc = '0;
			end
			default: begin k = dndc_pkg::DAYS_1Y; inc = '0; end
		endcase
	end

	// the shared unit
	assign diff = {1'b0, rem_q} - {1'b0, k};
	assign ge   = ~diff[dndc_pkg::DAYS_W];

	always_comb begin
		unique case (phase_q)
			PH_400:  take = ge;
			PH_100:  take = ge && (c100_q != 2'd3);
			PH_4:    take = ge;
			PH_1:    take = ge && (c1_q != 2'd3);
			PH_MON:  take = ge && (mon_q != dndc_pkg::MONTH_LAST);
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: if (start) phase_q <= PH_400;
				PH_400:  if (!take) phase_q <= PH_100;
				PH_100:  if (!take) phase_q <= PH_4;
				PH_4:    if (!take) phase_q <= PH_1;
				PH_1:    if (!take) phase_q <= PH_MON;
				PH_MON:  begin
					if (!take) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE) begin
			if (start) begin
				rem_q  <= n_days;
				year_q <= 14'd1;
				mon_q  <= '0;
				c100_q <= '0;
				c4_q   <= '0;
				c1_q   <= '0;
			end
		end else if (take) begin
			rem_q  <= diff[dndc_pkg::DAYS_W-1:0];
			year_q <= year_q + inc;
			if (phase_q == PH_100) c100_q <= c100_q + 2'd1;
			if (phase_q == PH_4)   c4_q   <= c4_q + 5'd1;
			if (phase_q == PH_1)   c1_q   <= c1_q + 2'd1;
			if (phase_q == PH_MON) mon_q  <= mon_q + 4'd1;
		end
	end

	assign done      = done_q;
	assign res.year  = year_q;
	assign res.month = mon_q + 4'd1;
	assign res.day   = rem_q[dndc_pkg::DAY_W-1:0] + 5'd1;

endmodule

// ===== hdl/day_number_date_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_number_date_converter_unit: Gregorian date <-> day count converter
// Converts a date to a day count since 1 Jan of EPOCH_YEAR, or a count to a
// date, and reports count, date, weekday and range flag for either one.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | transfer
//  --------+-------------------------------------------+-----+--------------------
//  in      | in_valid/in_ready, action, in_day,        | in  | valid & ready
//          | in_month, in_year, in_count               |     |
//  out     | out_valid/out_ready, day_count, out_day,  | out | valid & ready
//          | out_month, out_year, weekday, in_range    |     |
//  cfg     | cfg_wr_en, cfg_wr_data (start_weekday)    | in  | cfg_wr_en, no wait
//
// Steps: date to count runs the multiply/add states ST_MULQ, ST_MULC, ST_MULP,
// ST_SUMB and ST_SUMC; both actions then launch the splitter in ST_GO, where
// one subtractor peels year blocks and months, and hand off via ST_WAIT and
// ST_DONE. The 400 year peel of a count near the top of the range is worst.
// One transaction is in flight; in_ready is high only while idle.
// A finished result waits in the output register; a stalled out_ready holds
// the block in its done state. Reset clears control and sets start_weekday to 4.
//
module day_number_date_converter_unit #(
	parameter int EPOCH_YEAR = 1970,
	parameter int LAST_YEAR  = 9999
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input transactions
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [dndc_pkg::DAY_W-1:0]     in_day,
	input  logic [dndc_pkg::MONTH_W-1:0]   in_month,
	input  logic [dndc_pkg::YEAR_W-1:0]    in_year,
	input  logic [dndc_pkg::COUNT_W-1:0]   in_count,
	// result transactions
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dndc_pkg::COUNT_W-1:0]   day_count,
	output logic [dndc_pkg::DAY_W-1:0]     out_day,
	output logic [dndc_pkg::MONTH_W-1:0]   out_month,
	output logic [dndc_pkg::YEAR_W-1:0]    out_year,
	output logic [dndc_pkg::WDAY_W-1:0]    weekday,
	output logic                           in_range,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [dndc_pkg::WDAY_W-1:0]    cfg_wr_data
);

	// day numbers counted from 1 Jan of year 1
	localparam logic [dndc_pkg::DAYS_W-1:0] DbyEpoch =
		dndc_pkg::DAYS_W'(dndc_pkg::days_before_year(EPOCH_YEAR));
	localparam logic [dndc_pkg::DAYS_W-1:0] LastCount =
		dndc_pkg::DAYS_W'(dndc_pkg::days_before_year(LAST_YEAR + 1)
		                  - dndc_pkg::days_before_year(EPOCH_YEAR) - 1);
	localparam logic [dndc_pkg::YEAR_W-1:0] YearLo = dndc_pkg::YEAR_W'(EPOCH_YEAR);
	localparam logic [dndc_pkg::YEAR_W-1:0] YearHi = dndc_pkg::YEAR_W'(LAST_YEAR);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MULQ  = 9'b000000010,   // y / 100 by reciprocal
		ST_MULC  = 9'b000000100,   // century check
		ST_MULP  = 9'b000001000,   // 365 * (y - 1), leap flag
		ST_SUMB  = 9'b000010000,   // days before year
		ST_SUMC  = 9'b000100000,   // day count
		ST_GO    = 9'b001000000,   // launch splitter
		ST_WAIT  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t                              state_q;
	logic [dndc_pkg::WDAY_W-1:0]         sw_q;
	logic                                out_valid_q;

	// working registers of the date to count path
	logic [dndc_pkg::YEAR_W-1:0]         y_q;
	logic [dndc_pkg::MONTH_W-1:0]        m_q;        // zero based
	logic [dndc_pkg::DAY_W-1:0]          d_q;
	logic [dndc_pkg::Q100_W-1:0]         yq_q;       // y / 100
	logic                                c100_q;     // y divisible by 100
	logic                                leap_q;
	logic [dndc_pkg::DAYS_W-1:0]         p365_q;
	logic [dndc_pkg::DAYS_W-1:0]         base_q;
	logic [dndc_pkg::COUNT_W-1:0]        cnt_q;

	// result register
	logic [dndc_pkg::COUNT_W-1:0]        day_count_q;
	dndc_pkg::date_t                     date_q;
	logic [dndc_pkg::WDAY_W-1:0]         weekday_q;
	logic                                in_range_q;

	logic                                in_fire;
	logic                                out_free;
	logic                                split_start;
	logic                                split_done;
	dndc_pkg::date_t                     split_res;

	logic [dndc_pkg::YEAR_W-1:0]         y_clamp;
	logic [dndc_pkg::MONTH_W-1:0]        m_clamp;
	logic [26:0]                         yq_prod;
	logic [dndc_pkg::YEAR_W-1:0]         yq100;
	logic [dndc_pkg::YEAR_W-1:0]         p;
	logic [dndc_pkg::Q100_W-1:0]         pq;         // (y - 1) / 100
	logic [dndc_pkg::DAYS_W-1:0]         cnt_sum;
	logic [dndc_pkg::DAYS_W-1:0]         n_days;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// clamp year into epoch..last year, month into January..December
	always_comb begin
		if (in_year < YearLo) begin
			y_clamp = YearLo;
		end else if (in_year > YearHi) begin
			y_clamp = YearHi;
		end else begin
			y_clamp = in_year;
		end
		if (in_month == 4'd0) begin
			m_clamp = 4'd0;
		end else if (in_month > 4'd12) begin
			m_clamp = dndc_pkg::MONTH_LAST;
		end else begin
			m_clamp = in_month - 4'd1;
		end
	end

	assign yq_prod = 27'(y_q) * 27'(dndc_pkg::RECIP_100);
	assign yq100   = dndc_pkg::YEAR_W'(yq_q) * dndc_pkg::YEAR_W'(dndc_pkg::HUNDRED);
	assign p       = y_q - 14'd1;
	assign pq      = c100_q ? (yq_q - 7'd1) : yq_q;

	// a day of zero wraps the count modulo 2^22
	assign cnt_sum = base_q - DbyEpoch
	               + dndc_pkg::DAYS_W'(dndc_pkg::month_offset(leap_q, m_q))
	               + dndc_pkg::DAYS_W'(d_q) - 23'd1;

	assign n_days      = {1'b0, cnt_q} + DbyEpoch;
	assign split_start = (state_q == ST_GO);

	dndc_split u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (split_start),
		.n_days (n_days),
		.done   (split_done),
		.res    (split_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sw_q        <= 3'd4;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) sw_q <= cfg_wr_data;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= action ? ST_GO : ST_MULQ;
				end
				ST_MULQ: state_q <= ST_MULC;
				ST_MULC: state_q <= ST_MULP;
				ST_MULP: state_q <= ST_SUMB;
				ST_SUMB: state_q <= ST_SUMC;
				ST_SUMC: state_q <= ST_GO;
				ST_GO:   state_q <= ST_WAIT;
				ST_WAIT: if (split_done) state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			y_q   <= y_clamp;
			m_q   <= m_clamp;
			d_q   <= in_day;
			cnt_q <= in_count;
		end
		if (state_q == ST_MULQ) begin
			yq_q <= yq_prod[dndc_pkg::RECIP_SHR +: dndc_pkg::Q100_W];
		end
		if (state_q == ST_MULC) begin
			c100_q <= (yq100 == y_q);
		end
		if (state_q == ST_MULP) begin
			p365_q <= dndc_pkg::DAYS_W'(p) * dndc_pkg::DAYS_W'(dndc_pkg::DAYS_YEAR);
			leap_q <= (y_q[1:0] == 2'd0) && (!c100_q || (yq_q[1:0] == 2'd0));
		end
		if (state_q == ST_SUMB) begin
			base_q <= p365_q + dndc_pkg::DAYS_W'(p[dndc_pkg::YEAR_W-1:2])
			        - dndc_pkg::DAYS_W'(pq) + dndc_pkg::DAYS_W'(pq[dndc_pkg::Q100_W-1:2]);
		end
		if (state_q == ST_SUMC) begin
			cnt_q <= cnt_sum[dndc_pkg::COUNT_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			day_count_q <= cnt_q;
			date_q      <= split_res;
			weekday_q   <= dndc_pkg::mod7(cnt_q, sw_q);
			in_range_q  <= ({1'b0, cnt_q} <= LastCount);
		end
	end

	assign out_valid = out_valid_q;
	assign day_count = day_count_q;
	assign out_day   = date_q.day;
	assign out_month = date_q.month;
	assign out_year  = date_q.year;
	assign weekday   = weekday_q;
	assign in_range  = in_range_q;

endmodule

// ===== sim/day_number_date_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_number_date_converter_unit_tb: self-checking bench of the date converter
// Drives date-to-count and count-to-date transactions with bursty input and a
// stalling output, predicts every result with a calendar model of its own and
// checks each result field by field, across several start weekday settings.
// ----------------------------------------------------------------------------
module day_number_date_converter_unit_tb;

	localparam int COUNT_W = dndc_pkg::COUNT_W;
	localparam int DAY_W   = dndc_pkg::DAY_W;
	localparam int MONTH_W = dndc_pkg::MONTH_W;
	localparam int YEAR_W  = dndc_pkg::YEAR_W;
	localparam int WDAY_W  = dndc_pkg::WDAY_W;

	localparam int EPOCH    = 1970;
	localparam int LAST     = 9999;
	localparam int ERA_DAYS = 146097;      // one full 400 year Gregorian cycle
	localparam int MAX_PRINTED = 40;       // keeps a broken build from flooding the log
	// Worst correct case without a transaction: a busy conversion, the receiver
	// hold and a sender gap. Taken several times over.
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 100;      // roughly one worst case conversion

	// one predicted or observed result transaction
	typedef struct {
		logic [COUNT_W-1:0] count;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [WDAY_W-1:0]  wday;
		logic               rng;
	} civil_rec_t;

	// ------------------------------------------------------------------------
	// Scoreboard: calendar predictor plus the queue of expected results
	// ------------------------------------------------------------------------
	class calendar_scoreboard;
		civil_rec_t    expected_q[$];
		logic [WDAY_W-1:0] start_wd;
		int last_day;      // count of 31 Dec of the last year
		int mismatches;
		int n_checked;
		int n_date;
		int n_count;
		int n_beyond;

		function new();
			int yy;
			start_wd = 3'd4;
			last_day = -1;
			for (yy = EPOCH; yy <= LAST; yy++) begin
				last_day += year_days(yy);
			end
			mismatches = 0;
			n_checked  = 0;
			n_date     = 0;
			n_count    = 0;
			n_beyond   = 0;
		endfunction

		function bit leap_year(int y);
			return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
		endfunction

		function int year_days(int y);
			return leap_year(y) ? 366 : 365;
		endfunction

		// m0 is zero based
		function int month_days(bit lp, int m0);
			case (m0)
				1:             return lp ? 29 : 28;
				3, 5, 8, 10:   return 30;
				default:       return 31;
			endcase
		endfunction

		// clamp year and month, then sum whole years, whole months and the day
		function logic [COUNT_W-1:0] count_from_date(int d, int m, int y);
			int acc;
			int yy;
			int i;
			bit lp;
			if (y < EPOCH) y = EPOCH;
			if (y > LAST) y = LAST;
			if (m < 1) m = 1;
			if (m > 12) m = 12;
			acc = 0;
			for (yy = EPOCH; yy < y; yy++) begin
				acc += year_days(yy);
			end
			lp = leap_year(y);
			for (i = 0; i + 1 < m; i++) begin
				acc += month_days(lp, i);
			end
			acc += d - 1;     // day zero goes negative and wraps below
			return acc[COUNT_W-1:0];
		endfunction

		function civil_rec_t civil_from_count(logic [COUNT_W-1:0] c);
			civil_rec_t r;
			int rem;
			int y;
			int m;
			bit lp;
			rem = int'(c) + 1;
			y = EPOCH;
			m = 0;
			while (rem > ERA_DAYS) begin
				rem -= ERA_DAYS;
				y += 400;
			end
			while (rem > year_days(y)) begin
				rem -= year_days(y);
				y++;
			end
			lp = leap_year(y);
			while (m < 11 && rem > month_days(lp, m)) begin
				rem -= month_days(lp, m);
				m++;
			end
			r.count = c;
			r.day   = rem[DAY_W-1:0];
			r.month = MONTH_W'(m + 1);
			r.year  = y[YEAR_W-1:0];
			r.wday  = WDAY_W'((int'(start_wd) + int'(c % 7)) % 7);
			r.rng   = (int'(c) <= last_day);
			return r;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTED) begin
				$display("[%0t] MISMATCH %s", $realtime, msg);
			end
		endtask

		// called for every accepted input transaction
		task note_input(logic act, logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
				logic [YEAR_W-1:0] y, logic [COUNT_W-1:0] c);
			logic [COUNT_W-1:0] cnt;
			civil_rec_t r;
			if (act) begin
				cnt = c;
				n_count++;
			end else begin
				cnt = count_from_date(int'(d), int'(m), int'(y));
				n_date++;
			end
			r = civil_from_count(cnt);
			if (!r.rng) n_beyond++;
			expected_q.push_back(r);
		endtask

		task compare_field(string name, int got, int want);
			if (got != want) begin
				report($sformatf("result %0d %s: got %0d expected %0d",
					n_checked, name, got, want));
			end
		endtask

		// called for every accepted result transaction
		task check_result(civil_rec_t got);
			civil_rec_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with none expected, day_count %0d", got.count));
			end else begin
				want = expected_q.pop_front();
				compare_field("day_count", got.count, want.count);
				compare_field("out_day",   got.day,   want.day);
				compare_field("out_month", got.month, want.month);
				compare_field("out_year",  got.year,  want.year);
				compare_field("weekday",   got.wday,  want.wday);
				compare_field("in_range",  got.rng,   want.rng);
				n_checked++;
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 action;
	logic [DAY_W-1:0]     in_day;
	logic [MONTH_W-1:0]   in_month;
	logic [YEAR_W-1:0]    in_year;
	logic [COUNT_W-1:0]   in_count;
	logic                 out_valid;
	logic                 out_ready;
	logic [COUNT_W-1:0]   day_count;
	logic [DAY_W-1:0]     out_day;
	logic [MONTH_W-1:0]   out_month;
	logic [YEAR_W-1:0]    out_year;
	logic [WDAY_W-1:0]    weekday;
	logic                 in_range;
	logic                 cfg_wr_en;
	logic [WDAY_W-1:0]    cfg_wr_data;

	calendar_scoreboard sb = new();

	bit hold_req;        // main sequence asks the receiver for one long hold
	int n_settings;      // weekday settings the run went through
	int idle_cycles;

	day_number_date_converter_unit #(
		.EPOCH_YEAR (EPOCH),
		.LAST_YEAR  (LAST)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.in_day      (in_day),
		.in_month    (in_month),
		.in_year     (in_year),
		.in_count    (in_count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.day_count   (day_count),
		.out_day     (out_day),
		.out_month   (out_month),
		.out_year    (out_year),
		.weekday     (weekday),
		.in_range    (in_range),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Input side. Everything here changes on the falling edge; the handshake
	// is sampled on the rising edge, where DUT outputs still hold their
	// pre-edge values.
	// ------------------------------------------------------------------------

	// Offer one transaction and hold it until accepted. Returns on the next
	// falling edge with in_valid still high, so back-to-back items keep
	// valid asserted across the boundary.
	task send_item(logic act, logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
			logic [YEAR_W-1:0] y, logic [COUNT_W-1:0] c);
		in_valid = 1'b1;
		action   = act;
		in_day   = d;
		in_month = m;
		in_year  = y;
		in_count = c;
		do @(posedge clk); while (!in_ready);
		sb.note_input(action, in_day, in_month, in_year, in_count);
		@(negedge clk);
	endtask

	// the unused field group always carries random noise
	task send_date(int d, int m, int y);
		send_item(1'b0, DAY_W'(d), MONTH_W'(m), YEAR_W'(y), COUNT_W'($urandom));
	endtask

	task send_count(int c);
		send_item(1'b1, DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom),
			COUNT_W'(c));
	endtask

	// block is idle once the last expected result has been taken
	task drain();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task write_weekday(logic [WDAY_W-1:0] v);
		cfg_wr_data = v;
		cfg_wr_en   = 1'b1;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		sb.start_wd = v;
		n_settings++;
	endtask

	// Edges of every field, clamping, rollover, day zero wrap, century rules,
	// the last day boundary and the count wrap.
	task run_directed();
		send_date(1, 1, EPOCH);
		send_date(31, 12, LAST);
		send_date(0, 1, EPOCH);             // wraps to the top count
		send_date(15, 6, 0);                // year below epoch
		send_date(31, 15, 16383);           // year and month above range
		send_date(10, 0, 1969);             // month zero
		send_date(1, 1, LAST + 1);
		send_date(29, 2, 2000);             // 400 year leap
		send_date(29, 2, 2100);             // century, not leap: rolls to March
		send_date(31, 2, 2024);
		send_date(31, 4, 1999);
		send_date(1, 3, 2100);
		send_date(31, 12, 2000);
		send_date(0, 3, 2400);
		send_count(0);
		send_count(sb.last_day);
		send_count(sb.last_day + 1);        // first day past the last year
		send_count(22'h3FFFFF);
		send_count(ERA_DAYS - 1);
		send_count(ERA_DAYS);
		send_count(788);                    // 28 Feb 1972
		send_count(789);
		send_count(22'h2AAAAA);
		send_count(22'h155555);
	endtask

	// Mostly sane dates and in-range counts, with raw field noise and the
	// region around the last day mixed in.
	task send_random_item();
		int sel;
		int d;
		int m;
		int y;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			y = $urandom_range(EPOCH, LAST);
			if ($urandom_range(0, 4) == 0) y = 100 * $urandom_range(20, 99);
			m = $urandom_range(1, 12);
			d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28);
			send_date(d, m, y);
		end else if (sel < 60) begin
			send_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
		end else if (sel < 85) begin
			send_count($urandom_range(0, sb.last_day));
		end else if (sel < 93) begin
			send_count(sb.last_day + $urandom_range(0, 10) - 5);
		end else begin
			send_count($urandom_range(0, 22'h3FFFFF));
		end
	endtask

	// One phase: go idle, set the weekday, then bursts of random length with
	// random gaps. Long bursts give stretches without any sender idling.
	task run_phase(logic [WDAY_W-1:0] wd, int n_items, bit with_hold);
		int burst_left;
		int i;
		drain();
		write_weekday(wd);
		if (with_hold) hold_req = 1'b1;
		burst_left = 0;
		for (i = 0; i < n_items; i++) begin
			if (burst_left == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				                                         : $urandom_range(1, 8);
			end
			send_random_item();
			burst_left--;
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side: the receiver stalls on a cycling pattern of its own, with
	// occasional always-ready stretches and one long hold on request.
	// ------------------------------------------------------------------------
	initial begin
		int hold_cnt;
		int beat;
		int stall_mode;
		hold_cnt   = 0;
		beat       = 0;
		stall_mode = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				out_ready = 1'b0;
				hold_cnt--;
			end else if (hold_req) begin
				// block finishes one item, then backs up into the sender
				hold_req  = 1'b0;
				hold_cnt  = HOLD_CYCLES;
				out_ready = 1'b0;
			end else begin
				beat++;
				case (stall_mode)
					0:       out_ready = 1'b1;
					1:       out_ready = (beat % 3) != 0;
					2:       out_ready = (beat % 7) < 2;
					default: out_ready = $urandom_range(0, 3) != 0;
				endcase
				if (beat % 97 == 0) stall_mode = $urandom_range(0, 3);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		civil_rec_t got;
		if (arst_n && out_valid && out_ready) begin
			got.count = day_count;
			got.day   = out_day;
			got.month = out_month;
			got.year  = out_year;
			got.wday  = weekday;
			got.rng   = in_range;
			sb.check_result(got);
		end
	end

	// watchdog: too long without any transaction on either side
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
					$realtime, idle_cycles, sb.pending());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = 1'b0;
		in_day      = '0;
		in_month    = '0;
		in_year     = '0;
		in_count    = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		hold_req    = 1'b0;
		n_settings  = 1;      // reset value counts as the first setting
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();                         // reset weekday, Thursday
		run_phase(3'd0, 150, 1'b0);
		run_phase(3'd7, 150, 1'b1);             // out of range weekday, long hold
		run_phase(3'd6, 150, 1'b0);
		run_phase(WDAY_W'($urandom_range(1, 5)), 230, 1'b1);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);    // catch stray results

		$display("Covered %0d date-to-count and %0d count-to-date transactions",
			sb.n_date, sb.n_count);
		$display("over %0d weekday settings; checked %0d results, %0d past the last year.",
			n_settings, sb.n_checked, sb.n_beyond);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
